[rtl/core/ray_parallelogram_intersect_top_assert.svh]
// Assertion macros for the ray and parallelogram intersection block.
`ifndef RAY_PARALLELOGRAM_INTERSECT_TOP_ASSERT_SVH
`define RAY_PARALLELOGRAM_INTERSECT_TOP_ASSERT_SVH
`ifndef SYNTH
`define RPI_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RPI_ASSERT_RESET(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPI_ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define RPI_ASSERT_RESET(lbl, clk, rst_n, prop, msg)
`endif
`endif

[rtl/core/rpi_pkg.sv]
// Shared constants and register indexes of the ray and parallelogram intersection block.
`timescale 1ns / 1ps
package rpi_pkg;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 60;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_POINT  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_NORMAL = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_U       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_V       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MATERIAL_ID  = 3'd4;
    localparam int MATERIAL_BITS = 16;
endpackage

[rtl/core/rpi_stream_if.sv]
// Valid/ready channel carrying a payload of a given width.
`timescale 1ns / 1ps
interface rpi_stream_if #(
    parameter int WIDTH = 120
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/rpi_divider.sv]
// Pipelined restoring divider for the ray parameter, one quotient bit per stage.
`timescale 1ns / 1ps
module rpi_divider #(
    parameter int QBITS  = 19,
    parameter int NBITS  = 64,
    parameter int SBITS  = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NBITS-1:0] i_numer,
    input  logic [NBITS-1:0] i_den,
    input  logic [SBITS-1:0] i_side,
    output logic             o_valid,
    output logic [QBITS-1:0] o_quot,
    output logic [SBITS-1:0] o_side
);
    // Stage k decides quotient bit QBITS-1-k; remainder stays below den << bit.
    logic             r_v   [1:QBITS];
    logic [NBITS-1:0] r_rem [1:QBITS];
    logic [NBITS-1:0] r_den [1:QBITS];
    logic [QBITS-1:0] r_q   [1:QBITS];
    logic [SBITS-1:0] r_s   [1:QBITS];

    for (genvar k = 0; k < QBITS; k++) begin : g_stage
        localparam int B = QBITS - 1 - k;
        logic                   w_vi;
        logic [NBITS-1:0]       w_ri, w_di;
        logic [QBITS-1:0]       w_qi;
        logic [SBITS-1:0]       w_si;
        logic [NBITS+QBITS-1:0] w_sub;
        logic                   w_take;
        // The first stage takes its operands straight from the inputs.
        if (k == 0) begin : g_first
            assign w_vi = i_valid;
            assign w_ri = i_numer;
            assign w_di = i_den;
            assign w_qi = '0;
            assign w_si = i_side;
        end else begin : g_next
            assign w_vi = r_v[k];
            assign w_ri = r_rem[k];
            assign w_di = r_den[k];
            assign w_qi = r_q[k];
            assign w_si = r_s[k];
        end
        assign w_sub  = {{QBITS{1'b0}}, w_di} << B;
        assign w_take = {{QBITS{1'b0}}, w_ri} >= w_sub;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= w_vi;
            end
            if (i_en) begin
                r_rem[k+1] <= w_take ? w_ri - w_sub[NBITS-1:0] : w_ri;
                r_den[k+1] <= w_di;
                r_q[k+1]   <= w_qi | (QBITS'(w_take) << B);
                r_s[k+1]   <= w_si;
            end
        end
    end

    assign o_valid = r_v[QBITS];
    assign o_quot  = r_q[QBITS];
    assign o_side  = r_s[QBITS];
endmodule

[rtl/core/ray_parallelogram_intersect_top.sv]
// Top level of the ray and parallelogram intersection pipeline.
`timescale 1ns / 1ps
`include "ray_parallelogram_intersect_top_assert.svh"
// One ray enters per cycle while the output is not stalled; its result passes
// seven arithmetic stages and the output register, plus one divider stage per
// distance bit; the pipeline is stalled as a whole by output back-pressure.
// Rays face the patch only when N.D is negative; the distance is
// floor(-N.(P-O) * 2^FRAC_BITS / -N.D) and saturates, misses read all zero.
module ray_parallelogram_intersect_top #(
    parameter int COORD_BITS = 20,
    parameter int FRAC_BITS  = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rpi_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [3*COORD_BITS-1:0]           i_cfg_data,
    rpi_stream_if.sink                        s_ray,
    rpi_stream_if.source                      m_hit
);
    localparam int CB = COORD_BITS;
    localparam int VB = 3 * CB;
    localparam int PB = 2 * CB + 2;          // product of two diffs
    localparam int DB = PB + 2;              // dot of three
    localparam int NB = DB + FRAC_BITS + 1;  // shifted numerator
    localparam int QB = CB - 1;
    localparam int MB = rpi_pkg::MATERIAL_BITS;
    localparam logic signed [CB:0] CAP = (CB+1)'((1 << (CB - 1)) - 1);

    // Origin x sits in the low bits of the request, direction z in the high bits.
    typedef struct packed {
        logic signed [CB-1:0] dz, dy, dx, oz, oy, ox;
    } t_ray;

    // Configuration registers.
    logic [VB-1:0] r_pt, r_nrm, r_eu, r_ev;
    logic [MB-1:0] r_mat;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt <= '0; r_nrm <= '0; r_eu <= '0; r_ev <= '0; r_mat <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rpi_pkg::REG_PLANE_POINT:  r_pt  <= i_cfg_data;
                rpi_pkg::REG_PLANE_NORMAL: r_nrm <= i_cfg_data;
                rpi_pkg::REG_EDGE_U:       r_eu  <= i_cfg_data;
                rpi_pkg::REG_EDGE_V:       r_ev  <= i_cfg_data;
                rpi_pkg::REG_MATERIAL_ID:  r_mat <= i_cfg_data[MB-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic signed [CB-1:0] cmp(input logic [VB-1:0] v, input int i);
        return v[i*CB +: CB];
    endfunction

    logic signed [CB-1:0] w_px, w_py, w_pz, w_nx, w_ny, w_nz;
    logic signed [CB-1:0] w_ux, w_uy, w_uz, w_vx, w_vy, w_vz;
    assign w_px = cmp(r_pt, 0);  assign w_py = cmp(r_pt, 1);  assign w_pz = cmp(r_pt, 2);
    assign w_nx = cmp(r_nrm, 0); assign w_ny = cmp(r_nrm, 1); assign w_nz = cmp(r_nrm, 2);
    assign w_ux = cmp(r_eu, 0);  assign w_uy = cmp(r_eu, 1);  assign w_uz = cmp(r_eu, 2);
    assign w_vx = cmp(r_ev, 0);  assign w_vy = cmp(r_ev, 1);  assign w_vz = cmp(r_ev, 2);

    // The whole pipeline advances when the output register can move.
    logic w_en;
    logic r_ov;
    assign w_en = !r_ov || m_hit.ready;
    assign s_ray.ready = w_en;

    t_ray w_in;
    assign w_in = t_ray'(s_ray.data);

    // Stage 1: register ray and origin offset P-O.
    logic r1_v;
    t_ray r1_ray;
    logic signed [CB:0] r1_fx, r1_fy, r1_fz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (w_en) r1_v <= s_ray.valid;
        if (w_en) begin
            r1_ray <= w_in;
            r1_fx <= (CB+1)'(w_px) - (CB+1)'(w_in.ox);
            r1_fy <= (CB+1)'(w_py) - (CB+1)'(w_in.oy);
            r1_fz <= (CB+1)'(w_pz) - (CB+1)'(w_in.oz);
        end
    end

    // Stage 2: products for N.D and N.(P-O).
    logic r2_v;
    t_ray r2_ray;
    logic signed [PB-1:0] r2_d0, r2_d1, r2_d2, r2_n0, r2_n1, r2_n2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (w_en) r2_v <= r1_v;
        if (w_en) begin
            r2_ray <= r1_ray;
            r2_d0 <= PB'(w_nx) * PB'(r1_ray.dx);
            r2_d1 <= PB'(w_ny) * PB'(r1_ray.dy);
            r2_d2 <= PB'(w_nz) * PB'(r1_ray.dz);
            r2_n0 <= PB'(w_nx) * PB'(r1_fx);
            r2_n1 <= PB'(w_ny) * PB'(r1_fy);
            r2_n2 <= PB'(w_nz) * PB'(r1_fz);
        end
    end

    // Stage 3: dot sums and facing test.
    logic r3_v, r3_ok;
    t_ray r3_ray;
    logic signed [DB-1:0] w_nd, w_num;
    logic [NB-1:0] r3_numer, r3_den;
    logic r3_sat;
    assign w_nd  = DB'(r2_d0) + DB'(r2_d1) + DB'(r2_d2);
    assign w_num = DB'(r2_n0) + DB'(r2_n1) + DB'(r2_n2);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (w_en) r3_v <= r2_v;
        if (w_en) begin
            r3_ray   <= r2_ray;
            r3_ok    <= w_nd[DB-1] && (w_num <= 0);
            r3_numer <= NB'(-w_num) << FRAC_BITS;
            r3_den   <= NB'(-w_nd);
        end
    end

    // Stage 4: saturation test against den * 2^(CB-1), wide enough not to wrap.
    logic r4_v;
    logic [NB-1:0] r4_numer, r4_den;
    logic [1+1+6*CB-1:0] r4_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (w_en) r4_v <= r3_v;
        if (w_en) begin
            r4_numer <= r3_numer;
            r4_den   <= r3_den;
            r4_side  <= {r3_ok, ({{(CB-1){1'b0}}, r3_numer} >=
                                 ({{(CB-1){1'b0}}, r3_den} << (CB - 1))), r3_ray};
        end
    end
    assign r3_sat = 1'b0;

    // Distance divider, one bit per stage.
    logic          w_dv;
    logic [QB-1:0] w_q;
    logic [1+1+6*CB-1:0] w_side;
    rpi_divider #(.QBITS(QB), .NBITS(NB), .SBITS(2 + 6 * CB)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(r4_v), .i_numer(r4_numer), .i_den(r4_den),
        .i_side({r4_side[6*CB+1], r4_side[6*CB] | r3_sat, r4_side[6*CB-1:0]}),
        .o_valid(w_dv), .o_quot(w_q), .o_side(w_side)
    );

    t_ray w_dray;
    logic [QB-1:0] w_t;
    assign w_dray = t_ray'(w_side[6*CB-1:0]);
    assign w_t    = w_side[6*CB] ? CAP[QB-1:0] : w_q;

    // Stage 5: D*t products.
    logic r5_v, r5_ok;
    t_ray r5_ray;
    logic [QB-1:0] r5_t;
    logic signed [2*CB:0] r5_mx, r5_my, r5_mz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (w_en) r5_v <= w_dv;
        if (w_en) begin
            r5_ok  <= w_side[6*CB+1];
            r5_ray <= w_dray;
            r5_t   <= w_t;
            r5_mx  <= (2*CB+1)'(w_dray.dx) * $signed({2'b0, w_t});
            r5_my  <= (2*CB+1)'(w_dray.dy) * $signed({2'b0, w_t});
            r5_mz  <= (2*CB+1)'(w_dray.dz) * $signed({2'b0, w_t});
        end
    end

    function automatic logic signed [CB-1:0] hsat(input logic signed [CB-1:0] o,
                                                   input logic signed [2*CB:0] m);
        logic signed [2*CB+1:0] s;
        s = (2*CB+2)'(o) + (2*CB+2)'(m >>> FRAC_BITS);
        if (s > (2*CB+2)'(CAP)) return CAP[CB-1:0];
        if (s < -(2*CB+2)'(CAP) - 1) return ~CAP[CB-1:0];
        return s[CB-1:0];
    endfunction

    // Stage 6: hit point and offset from corner.
    logic r6_v, r6_ok;
    logic [QB-1:0] r6_t;
    logic signed [CB-1:0] r6_hx, r6_hy, r6_hz;
    logic signed [CB:0] r6_ex, r6_ey, r6_ez;
    logic signed [CB-1:0] w_hx, w_hy, w_hz;
    assign w_hx = hsat(r5_ray.ox, r5_mx);
    assign w_hy = hsat(r5_ray.oy, r5_my);
    assign w_hz = hsat(r5_ray.oz, r5_mz);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (w_en) r6_v <= r5_v;
        if (w_en) begin
            r6_ok <= r5_ok; r6_t <= r5_t;
            r6_hx <= w_hx; r6_hy <= w_hy; r6_hz <= w_hz;
            r6_ex <= (CB+1)'(w_hx) - (CB+1)'(w_px);
            r6_ey <= (CB+1)'(w_hy) - (CB+1)'(w_py);
            r6_ez <= (CB+1)'(w_hz) - (CB+1)'(w_pz);
        end
    end

    // Stage 7: edge products.
    logic r7_v, r7_ok;
    logic [QB-1:0] r7_t;
    logic signed [CB-1:0] r7_hx, r7_hy, r7_hz;
    logic signed [PB-1:0] r7_eu0, r7_eu1, r7_eu2, r7_ev0, r7_ev1, r7_ev2;
    logic signed [PB-1:0] r7_uu0, r7_uu1, r7_uu2, r7_vv0, r7_vv1, r7_vv2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (w_en) r7_v <= r6_v;
        if (w_en) begin
            r7_ok <= r6_ok; r7_t <= r6_t;
            r7_hx <= r6_hx; r7_hy <= r6_hy; r7_hz <= r6_hz;
            r7_eu0 <= PB'(r6_ex) * PB'(w_ux);
            r7_eu1 <= PB'(r6_ey) * PB'(w_uy);
            r7_eu2 <= PB'(r6_ez) * PB'(w_uz);
            r7_ev0 <= PB'(r6_ex) * PB'(w_vx);
            r7_ev1 <= PB'(r6_ey) * PB'(w_vy);
            r7_ev2 <= PB'(r6_ez) * PB'(w_vz);
            r7_uu0 <= PB'(w_ux) * PB'(w_ux);
            r7_uu1 <= PB'(w_uy) * PB'(w_uy);
            r7_uu2 <= PB'(w_uz) * PB'(w_uz);
            r7_vv0 <= PB'(w_vx) * PB'(w_vx);
            r7_vv1 <= PB'(w_vy) * PB'(w_vy);
            r7_vv2 <= PB'(w_vz) * PB'(w_vz);
        end
    end

    // Edge test and output register.
    logic signed [DB-1:0] w_eu, w_ev, w_uu, w_vv;
    logic w_in_patch, w_hit;
    assign w_eu = DB'(r7_eu0) + DB'(r7_eu1) + DB'(r7_eu2);
    assign w_ev = DB'(r7_ev0) + DB'(r7_ev1) + DB'(r7_ev2);
    assign w_uu = DB'(r7_uu0) + DB'(r7_uu1) + DB'(r7_uu2);
    assign w_vv = DB'(r7_vv0) + DB'(r7_vv1) + DB'(r7_vv2);
    assign w_in_patch = (w_uu == 0) || (w_vv == 0) ||
        (!w_eu[DB-1] && w_eu <= w_uu && !w_ev[DB-1] && w_ev <= w_vv);
    assign w_hit = r7_ok && w_in_patch;

    logic [1+3*CB+QB+MB+VB-1:0] r_od;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= r7_v;
        if (w_en) begin
            r_od <= w_hit ? {1'b1, r7_hz, r7_hy, r7_hx, r7_t, r_mat, r_nrm} : '0;
        end
    end
    assign m_hit.valid = r_ov;
    assign m_hit.data  = r_od;

    `RPI_ASSERT_IMPL(a_stall_hold, i_clk, i_rst_n, r_ov && !m_hit.ready |=> r_ov && $stable(r_od), "output lost under stall")
    `RPI_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, r_ov && !r_od[1+3*CB+QB+MB+VB-1] |-> r_od == '0, "miss result not zero")
    `RPI_ASSERT_RESET(a_reset_empty, i_clk, i_rst_n, !i_rst_n |=> !r_ov && !r1_v, "pipeline not empty after reset")
endmodule
